// ===== design/jrhs_pkg.sv =====
// Package for the job ratio heap sorter: word types and record layout.
// No dependencies.
`timescale 1ns / 1ps
package jrhs_pkg;
	typedef struct packed {
		logic [7:0]  job_name;
		logic [15:0] job_time;
		logic [15:0] job_cost;
		logic        last_item;
	} in_word_t;

	typedef struct packed {
		logic [7:0]  out_name;
		logic [15:0] out_time;
		logic [15:0] out_cost;
		logic        dropped;
		logic        last_out;
	} out_word_t;

	typedef struct packed {
		logic [7:0]  name;
		logic [15:0] time_v;
		logic [15:0] cost;
		logic [15:0] key;
		logic [5:0]  seq;
	} rec_t;

	localparam int KeyW = 16;
endpackage

// ===== design/job_ratio_heap_sorter_unit.sv =====
// Top level of the job ratio heap sorter: record memory and sort sequencer.
// Depends on jrhs_pkg and jrhs_divider.
//
// Input words (name, time, cost, last) are taken one at a time on the in
// channel. A stored word keeps the in channel busy while the restoring key
// divider forms its key and the record is written. A word dropped for lack
// of room is taken in idle without a division. A word whose last bit is set
// starts a heap sort of the stored set in the record memory, which has one
// write and one registered read port. Each sift level reads the parent and
// both children, compares them and writes back any swap; each extraction
// moves the root to the freed end slot and the last record to the root.
// Once the first read is primed, the sorted records leave on the out
// channel, largest key first, equal keys in load order, one word per cycle
// while out_ready is high; a stall holds the output register and the
// sequencer waits. Records beyond MAX_JOBS are discarded and flagged on every
// word of the run. Reset clears the count, the flag and all control state;
// memory contents are left as they are. The in channel is not ready while a
// word is divided or a set is sorted or emitted.
`timescale 1ns / 1ps
module job_ratio_heap_sorter_unit #(
	parameter int MAX_JOBS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  jrhs_pkg::in_word_t  in_word,
	output logic                out_valid,
	input  logic                out_ready,
	output jrhs_pkg::out_word_t out_word
);
	localparam int AW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
	localparam int CW = AW + 1;

	typedef enum logic [14:0] {
		S_IDLE  = 15'b000000000000001,
		S_DIV   = 15'b000000000000010,
		S_BUILD = 15'b000000000000100,
		S_RDP   = 15'b000000000001000,
		S_RDL   = 15'b000000000010000,
		S_RDR   = 15'b000000000100000,
		S_CMP   = 15'b000000001000000,
		S_SWP   = 15'b000000010000000,
		S_WRC   = 15'b000000100000000,
		S_EXT   = 15'b000001000000000,
		S_EXR   = 15'b000010000000000,
		S_EXW   = 15'b000100000000000,
		S_EXV   = 15'b001000000000000,
		S_EMRD  = 15'b010000000000000,
		S_EMIT  = 15'b100000000000000
	} state_t;

	state_t state_q;
	jrhs_pkg::rec_t mem [MAX_JOBS];
	jrhs_pkg::rec_t rd_q;
	logic [AW-1:0] rd_addr;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	jrhs_pkg::rec_t wr_data;

	logic [CW-1:0] count_q, len_q, cur_q, least_q, build_q, emit_q;
	logic [CW-1:0] emit_nx;
	logic          ovf_q, last_q;
	jrhs_pkg::in_word_t hold_q;
	jrhs_pkg::rec_t p_q, l_q, r_q, a_q;
	logic          is_build_q;
	logic          div_start, div_done;
	logic [jrhs_pkg::KeyW-1:0] quo;
	logic [CW:0]   lc, rc;
	logic          lbelow, rbelow, l_ok, r_ok;
	logic          emit_fire;
	jrhs_pkg::rec_t m_rec;

	function automatic logic below(jrhs_pkg::rec_t x, jrhs_pkg::rec_t y);
		if (x.key != y.key) return x.key < y.key;
		return x.seq > y.seq;
	endfunction

	jrhs_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(in_word.job_cost), .divisor(in_word.job_time),
		.done(div_done), .quotient(quo)
	);

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_q <= mem[rd_addr];
	end

	assign lc = {cur_q, 1'b1};
	assign rc = {cur_q, 1'b0} + {{CW{1'b0}}, 1'b1} + {{CW{1'b0}}, 1'b1};
	assign l_ok = lc < {1'b0, len_q};
	assign r_ok = rc < {1'b0, len_q};
	assign lbelow = l_ok && below(l_q, p_q);
	assign m_rec = lbelow ? l_q : p_q;
	assign rbelow = r_ok && below(r_q, m_rec);

	assign in_ready = (state_q == S_IDLE);
	assign div_start = in_valid && in_ready && (count_q < CW'(MAX_JOBS));
	assign emit_nx = emit_q + 1'b1;
	assign emit_fire = (state_q == S_EMIT) && (!out_valid || out_ready);

	always_comb begin
		rd_addr = cur_q[AW-1:0];
		case (state_q)
			S_RDL: rd_addr = lc[AW-1:0];
			S_RDR: rd_addr = rc[AW-1:0];
			S_EXT: rd_addr = '0;
			S_EXR: rd_addr = len_q[AW-1:0];
			S_EMRD: rd_addr = emit_q[AW-1:0];
			S_EMIT: rd_addr = emit_fire ? emit_nx[AW-1:0] : emit_q[AW-1:0];
			default: rd_addr = cur_q[AW-1:0];
		endcase
	end

	always_comb begin
		wr_en = 1'b0;
		wr_addr = cur_q[AW-1:0];
		wr_data = a_q;
		case (state_q)
			S_DIV: begin
				wr_en = div_done;
				wr_addr = count_q[AW-1:0];
				wr_data = '{name: hold_q.job_name, time_v: hold_q.job_time,
					cost: hold_q.job_cost, key: quo, seq: 6'(count_q)};
			end
			S_SWP: begin
				wr_en = rbelow || lbelow;
				wr_addr = cur_q[AW-1:0];
				wr_data = rbelow ? r_q : l_q;
			end
			S_WRC: begin
				wr_en = 1'b1;
				wr_addr = least_q[AW-1:0];
				wr_data = p_q;
			end
			S_EXW: begin
				wr_en = 1'b1;
				wr_addr = '0;
				wr_data = rd_q;
			end
			S_EXV: begin
				wr_en = 1'b1;
				wr_addr = len_q[AW-1:0];
				wr_data = a_q;
			end
			default: wr_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			ovf_q <= 1'b0;
			out_valid <= 1'b0;
			last_q <= 1'b0;
			len_q <= '0;
			cur_q <= '0;
			least_q <= '0;
			build_q <= '0;
			emit_q <= '0;
			is_build_q <= 1'b0;
			hold_q <= '0;
			p_q <= '0;
			l_q <= '0;
			r_q <= '0;
			a_q <= '0;
		end else begin
			if (emit_fire) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						hold_q <= in_word;
						last_q <= in_word.last_item;
						if (count_q < CW'(MAX_JOBS)) begin
							state_q <= S_DIV;
						end else begin
							ovf_q <= 1'b1;
							if (in_word.last_item) begin
								len_q <= count_q;
								build_q <= count_q >> 1;
								is_build_q <= 1'b1;
								state_q <= S_BUILD;
							end
						end
					end
				end
				S_DIV: begin
					if (div_done) begin
						count_q <= count_q + 1'b1;
						if (last_q) begin
							len_q <= count_q + 1'b1;
							build_q <= (count_q + 1'b1) >> 1;
							is_build_q <= 1'b1;
							state_q <= S_BUILD;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_BUILD: begin
					if (build_q != '0) begin
						cur_q <= build_q - 1'b1;
						build_q <= build_q - 1'b1;
						state_q <= S_RDP;
					end else begin
						is_build_q <= 1'b0;
						if (len_q > CW'(1)) begin
							len_q <= len_q - 1'b1;
							state_q <= S_EXT;
						end else begin
							emit_q <= '0;
							state_q <= S_EMRD;
						end
					end
				end
				S_RDP: state_q <= S_RDL;
				S_RDL: begin
					p_q <= rd_q;
					state_q <= S_RDR;
				end
				S_RDR: begin
					l_q <= rd_q;
					state_q <= S_CMP;
				end
				S_CMP: begin
					r_q <= rd_q;
					state_q <= S_SWP;
				end
				S_SWP: begin
					if (rbelow || lbelow) begin
						least_q <= rbelow ? rc[CW-1:0] : lc[CW-1:0];
						state_q <= S_WRC;
					end else if (is_build_q) begin
						state_q <= S_BUILD;
					end else if (len_q > CW'(1)) begin
						len_q <= len_q - 1'b1;
						state_q <= S_EXT;
					end else begin
						emit_q <= '0;
						state_q <= S_EMRD;
					end
				end
				S_WRC: begin
					cur_q <= least_q;
					state_q <= S_RDP;
				end
				S_EXT: state_q <= S_EXR;
				S_EXR: begin
					a_q <= rd_q;
					state_q <= S_EXW;
				end
				S_EXW: state_q <= S_EXV;
				S_EXV: begin
					cur_q <= '0;
					state_q <= S_RDP;
				end
				S_EMRD: state_q <= S_EMIT;
				S_EMIT: begin
					if (emit_fire) begin
						emit_q <= emit_nx;
						if (emit_nx == count_q) begin
							count_q <= '0;
							ovf_q <= 1'b0;
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			out_word.out_name <= rd_q.name;
			out_word.out_time <= rd_q.time_v;
			out_word.out_cost <= rd_q.cost;
			out_word.dropped <= ovf_q;
			out_word.last_out <= (emit_nx == count_q);
		end
	end
endmodule

// ===== design/jrhs_divider.sv =====
// Restoring divider, one quotient bit per cycle, for the record key.
// Depends on jrhs_pkg.
`timescale 1ns / 1ps
module jrhs_divider (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [jrhs_pkg::KeyW-1:0]  dividend,
	input  logic [jrhs_pkg::KeyW-1:0]  divisor,
	output logic                       done,
	output logic [jrhs_pkg::KeyW-1:0]  quotient
);
	logic [jrhs_pkg::KeyW-1:0] rem_q, quo_q, dvs_q;
	logic [4:0]                cnt_q;
	logic                      busy_q;
	logic [jrhs_pkg::KeyW:0]   trial;
	logic [jrhs_pkg::KeyW:0]   shifted;

	assign shifted = {rem_q, quo_q[jrhs_pkg::KeyW-1]};
	assign trial = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 5'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd15) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!trial[jrhs_pkg::KeyW]) begin
				rem_q <= trial[jrhs_pkg::KeyW-1:0];
				quo_q <= {quo_q[jrhs_pkg::KeyW-2:0], 1'b1};
			end else begin
				rem_q <= shifted[jrhs_pkg::KeyW-1:0];
				quo_q <= {quo_q[jrhs_pkg::KeyW-2:0], 1'b0};
			end
		end
	end

	assign quotient = (dvs_q == '0) ? '1 : quo_q;
endmodule
